@@ rtl/core/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the R250 generator RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define R250_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A property that must hold in the cycle after a triggering condition.
`define R250_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/r250_pkg.sv @@
// ============================================================================
// R250 generator package
// Types, constants and helper functions shared by the R250 generator RTL.
// ============================================================================
package r250_pkg;

    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned SEED_BITS  = 32;
    localparam int unsigned OUT_BITS   = 32;
    localparam int unsigned RING_DEPTH = 250;
    localparam int unsigned INDEX_BITS = $clog2(RING_DEPTH);
    localparam int unsigned TAP_DIST   = 103;
    localparam int unsigned FIX_START  = 3;
    localparam int unsigned FIX_STEP   = 11;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [SEED_BITS-1:0]  t_seed;
    typedef logic [OUT_BITS-1:0]   t_out;
    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [INDEX_BITS:0]   t_sum;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_GEN  = 1'b1
    } t_action;

    typedef struct packed {
        t_index rd_addr_a;
        t_index rd_addr_b;
        t_index wr_addr;
        t_word  load_word;
    } t_ring_req;

    function automatic t_word f_seed_to_word(t_seed s);
        t_word w;
        w = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i < SEED_BITS) begin
                w[i] = s[i];
            end
        end
        return w;
    endfunction

    function automatic t_out f_word_to_out(t_word w);
        t_out o;
        o = '0;
        for (int i = 0; i < OUT_BITS; i++) begin
            if (i < WORD_BITS) begin
                o[i] = w[i];
            end
        end
        return o;
    endfunction

    // Keeps the bit columns linearly independent: at position 3 + 11k the
    // word gets bit k set and every bit below it cleared.
    function automatic t_word f_fix_word(t_index p, t_word w);
        t_word r;
        t_word bit_k;
        t_sum  pos;
        r     = w;
        bit_k = '0;
        pos   = t_sum'(FIX_START);
        for (int k = 0; k < WORD_BITS; k++) begin
            if (p == pos[INDEX_BITS-1:0]) begin
                bit_k = t_word'(1) << k;
                r     = (w & ~(bit_k - t_word'(1))) | bit_k;
            end
            pos = pos + t_sum'(FIX_STEP);
            if (pos >= t_sum'(RING_DEPTH)) begin
                pos = pos - t_sum'(RING_DEPTH);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/r250_ptr.sv @@
// ============================================================================
// R250 pointer unit
// Holds the read and load pointers and forms the ring addresses and the
// fixed-up seed word for each accepted transaction.
// ============================================================================
`include "assert_macros.svh"

module r250_ptr
    import r250_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic      i_action,
    input  t_seed     i_seed_word,
    output t_ring_req o_req
);

    t_index r_read_index;
    t_index n_read_index;
    t_index r_load_index;
    t_index n_load_index;
    t_sum   tap_sum;
    t_sum   read_inc;
    t_sum   load_inc;

    always_comb begin
        tap_sum = {1'b0, r_read_index} + t_sum'(TAP_DIST);
        if (tap_sum >= t_sum'(RING_DEPTH)) begin
            tap_sum = tap_sum - t_sum'(RING_DEPTH);
        end
        read_inc = {1'b0, r_read_index} + t_sum'(1);
        if (read_inc >= t_sum'(RING_DEPTH)) begin
            read_inc = '0;
        end
        load_inc = {1'b0, r_load_index} + t_sum'(1);
        if (load_inc >= t_sum'(RING_DEPTH)) begin
            load_inc = '0;
        end
    end

    always_comb begin
        o_req.rd_addr_a = r_read_index;
        o_req.rd_addr_b = tap_sum[INDEX_BITS-1:0];
        o_req.wr_addr   = (i_action == ACT_GEN) ? r_read_index : r_load_index;
        o_req.load_word = f_fix_word(r_load_index, f_seed_to_word(i_seed_word));
    end

    always_comb begin
        n_read_index = r_read_index;
        n_load_index = r_load_index;
        if (i_fire) begin
            if (i_action == ACT_GEN) begin
                n_read_index = read_inc[INDEX_BITS-1:0];
            end else begin
                n_read_index = '0;
                n_load_index = load_inc[INDEX_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_index <= '0;
            r_load_index <= '0;
        end else begin
            r_read_index <= n_read_index;
            r_load_index <= n_load_index;
        end
    end

    `R250_ASSERT(a_read_in_range, i_clk, i_rst_n, r_read_index < t_index'(RING_DEPTH), "read pointer out of range")
    `R250_ASSERT(a_load_in_range, i_clk, i_rst_n, r_load_index < t_index'(RING_DEPTH), "load pointer out of range")
    `R250_ASSERT_NEXT(a_load_rewinds, i_clk, i_rst_n, i_fire && (i_action == ACT_LOAD), r_read_index == '0, "read pointer not rewound by load")

endmodule

@@ rtl/core/r250_ring.sv @@
// ============================================================================
// R250 ring store
// 250-word memory with two registered read ports and one write port, with
// forwarding of the write that lands in the same cycle as a read.
// ============================================================================
`include "assert_macros.svh"

module r250_ring
    import r250_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_rd_en,
    input  t_index i_rd_addr_a,
    input  t_index i_rd_addr_b,
    input  logic   i_wr_en,
    input  t_index i_wr_addr,
    input  t_word  i_wr_data,
    output t_word  o_rd_data_a,
    output t_word  o_rd_data_b
);

    t_word r_mem [RING_DEPTH];
    t_word r_rd_a;
    t_word r_rd_b;
    t_word r_fwd_data;
    logic  r_hit_a;
    logic  r_hit_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a     <= r_mem[i_rd_addr_a];
            r_rd_b     <= r_mem[i_rd_addr_b];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else if (i_rd_en) begin
            r_hit_a <= i_wr_en && (i_wr_addr == i_rd_addr_a);
            r_hit_b <= i_wr_en && (i_wr_addr == i_rd_addr_b);
        end
    end

    assign o_rd_data_a = r_hit_a ? r_fwd_data : r_rd_a;
    assign o_rd_data_b = r_hit_b ? r_fwd_data : r_rd_b;

    `R250_ASSERT(a_single_hit, i_clk, i_rst_n, !(r_hit_a && r_hit_b), "both read ports forwarded at once")

endmodule

@@ rtl/core/r250_gfsr_generator.sv @@
// ============================================================================
// R250 GFSR random word generator
// Seed loading and generation of R250 pseudo-random words from a 250-word
// ring, one transaction per cycle while no pending result is stalled.
// ============================================================================
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | i_action, i_seed_word
// result   | out       | o_valid / i_ready  | o_random_word (generate only)
//
// One transaction per cycle is sustained while no result stalls; the ring is
// read at the edge that accepts a generate transaction, and the XOR of the
// two read words lands in the output register, raising o_valid, as stage 1
// moves on. Load transactions give no result. The ring is not cleared by
// reset; all 250 entries must be loaded before generating. A stalled result
// holds the pipeline, while a load behind it still completes.
// ============================================================================
`include "assert_macros.svh"

module r250_gfsr_generator
    import r250_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_action,
    input  t_seed i_seed_word,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_random_word
);

    t_ring_req req;
    logic      in_fire;
    logic      s1_go;
    t_word     rd_a;
    t_word     rd_b;
    t_word     gen_word;
    t_word     wr_data;

    logic      r_s1_valid;
    logic      n_s1_valid;
    logic      r_s1_load;
    t_index    r_s1_addr;
    t_word     r_s1_word;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out      r_out_word;

    assign in_fire  = i_valid && o_ready;
    assign s1_go    = r_s1_valid && (r_s1_load || !r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || s1_go;
    assign gen_word = rd_a ^ rd_b;
    assign wr_data  = r_s1_load ? r_s1_word : gen_word;

    r250_ptr u_ptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_action    (i_action),
        .i_seed_word (i_seed_word),
        .o_req       (req)
    );

    r250_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (req.rd_addr_a),
        .i_rd_addr_b (req.rd_addr_b),
        .i_wr_en     (s1_go),
        .i_wr_addr   (r_s1_addr),
        .i_wr_data   (wr_data),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_go && !r_s1_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_load <= (i_action == ACT_LOAD);
            r_s1_addr <= req.wr_addr;
            r_s1_word <= req.load_word;
        end
        if (s1_go && !r_s1_load) begin
            r_out_word <= f_word_to_out(gen_word);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    `R250_ASSERT(a_no_overwrite, i_clk, i_rst_n,
                 !(s1_go && !r_s1_load && r_out_valid && !i_ready),
                 "pending result overwritten")
    `R250_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n,
                      s1_go && r_s1_load && (!r_out_valid || i_ready),
                      !r_out_valid, "load transaction produced a result")

endmodule

@@ tb/tb_r250_gfsr_generator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// R250 GFSR generator testbench
// Seeds the 250-word ring through load transactions, then mixes long runs of
// generate transactions with reloads, partial reseeds and full reseeds. Every
// generated word is compared with a behavioural model or with the word set in
// its directed row. Input is sent in bursts; output stalls on its own pattern.
// ============================================================================
module tb_r250_gfsr_generator;
    import r250_pkg::*;

    localparam int unsigned INV_FIX_STEP  = 91;
    localparam int unsigned RANDOM_ITEMS  = 900;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int          DIR_ROWS      = 15;

    typedef struct packed {
        t_action     act;
        t_seed       seed;
        int unsigned reps;
        logic        typed;
        t_out        want;
    } t_stim_row;

    // Zero and all-ones fills make the first words easy to work out by hand.
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        '{ACT_LOAD, 32'h0000_0000, 250, 1'b0, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 1,   1'b1, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 2,   1'b0, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 1,   1'b1, 32'h0000_0001},
        '{ACT_GEN,  32'h0000_0000, 20,  1'b0, 32'h0000_0000},
        '{ACT_LOAD, 32'hFFFF_FFFF, 250, 1'b0, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 1,   1'b1, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 5,   1'b0, 32'h0000_0000},
        '{ACT_LOAD, 32'h5555_5555, 1,   1'b0, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 1,   1'b1, 32'hAAAA_AAAA},
        '{ACT_LOAD, 32'hAAAA_AAAA, 1,   1'b0, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 3,   1'b0, 32'h0000_0000},
        '{ACT_LOAD, 32'h8000_0001, 1,   1'b0, 32'h0000_0000},
        '{ACT_LOAD, 32'h7FFF_FFFE, 1,   1'b0, 32'h0000_0000},
        '{ACT_GEN,  32'h0000_0000, 4,   1'b0, 32'h0000_0000}
    };

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_valid     = 1'b0;
    logic  o_ready;
    logic  i_action    = ACT_LOAD;
    t_seed i_seed_word = '0;
    logic  o_valid;
    logic  i_ready     = 1'b0;
    t_out  o_random_word;

    t_word       ring_model [RING_DEPTH];
    int unsigned gen_pos  = 0;
    int unsigned load_pos = 0;
    t_out        pending_words [$];
    t_out        head_word;

    int unsigned error_count     = 0;
    int unsigned results_checked = 0;
    int unsigned load_count      = 0;
    int unsigned gen_count       = 0;
    int unsigned cycle_count     = 0;
    int unsigned burst_left      = 0;
    int unsigned rx_count        = 0;

    r250_gfsr_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_seed_word   (i_seed_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_random_word (o_random_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Bit k is forced high, with everything below it cleared, at 3 + 11k.
    function automatic t_word fix_seed_word(int unsigned pos, t_word w);
        int unsigned k;
        t_word       bit_k;
        k = ((pos + RING_DEPTH - FIX_START) * INV_FIX_STEP) % RING_DEPTH;
        if (k < WORD_BITS) begin
            bit_k = t_word'(1) << k;
            return (w & ~(bit_k - t_word'(1))) | bit_k;
        end
        return w;
    endfunction

    function automatic void r250_load_word(t_seed seed);
        ring_model[load_pos] = fix_seed_word(load_pos, t_word'(seed));
        load_pos = (load_pos + 1) % RING_DEPTH;
        gen_pos  = 0;
    endfunction

    function automatic t_word r250_next_word();
        t_word w;
        w = ring_model[gen_pos] ^ ring_model[(gen_pos + TAP_DIST) % RING_DEPTH];
        ring_model[gen_pos] = w;
        gen_pos = (gen_pos + 1) % RING_DEPTH;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_transaction(input t_action act, input t_seed seed,
                                    input logic typed, input t_out want);
        t_word w;
        i_valid     <= 1'b1;
        i_action    <= act;
        i_seed_word <= seed;
        do @(posedge i_clk); while (!o_ready);
        if (act == ACT_LOAD) begin
            r250_load_word(seed);
            load_count++;
        end else begin
            w = r250_next_word();
            pending_words.push_back(typed ? want : t_out'(w));
            gen_count++;
        end
    endtask

    task automatic paced_send(input t_action act, input t_seed seed,
                              input logic typed, input t_out want);
        pace_sender();
        send_transaction(act, seed, typed, want);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // The output side cycles through free running, random and periodic stalls.
    always @(posedge i_clk) begin
        rx_count <= rx_count + 1;
        case ((rx_count / 300) % 3)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_ready <= ((rx_count % 7) >= 3);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_random_word));
            end else begin
                head_word = pending_words.pop_front();
                results_checked++;
                if (o_random_word !== head_word) begin
                    report_mismatch($sformatf("random_word got %h expected %h",
                                              o_random_word, head_word));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding",
                 pending_words.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned random_items;
        int unsigned run_len;
        int unsigned sel;
        int unsigned drain_cycles;
        logic        pressure_done;
        random_items  = 0;
        pressure_done = 1'b0;
        drain_cycles  = 0;

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int unsigned n = 0; n < DIRECTED[r].reps; n++) begin
                paced_send(DIRECTED[r].act, DIRECTED[r].seed, DIRECTED[r].typed,
                           DIRECTED[r].want);
            end
        end
        hold_until_drained();

        // Long generate runs wrap the read pointer; loads restart it at zero.
        while (random_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                for (int unsigned n = 0; n < RING_DEPTH; n++) begin
                    paced_send(ACT_LOAD, t_seed'($urandom), 1'b0, '0);
                    random_items++;
                end
            end else if (sel < 30) begin
                run_len = $urandom_range(1, 6);
                for (int unsigned n = 0; n < run_len; n++) begin
                    paced_send(ACT_LOAD, t_seed'($urandom), 1'b0, '0);
                    random_items++;
                end
            end else begin
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 400)
                                                      : $urandom_range(1, 60);
                for (int unsigned n = 0; n < run_len; n++) begin
                    paced_send(ACT_GEN, t_seed'($urandom), 1'b0, '0);
                    random_items++;
                end
            end
            if (!pressure_done && random_items >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                pressure_done = 1'b1;
            end
        end

        i_valid <= 1'b0;
        while (pending_words.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      pending_words.size()));
        end

        $display("Sent %0d loads and %0d generates, including full reseeds and ring wraps.",
                 load_count, gen_count);
        $display("Checked %0d words over %0d cycles, %0d mismatches.",
                 results_checked, cycle_count, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
